### hdl/bitmap_first_fit_allocator_unit_assert.svh
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_UNIT_ASSERT_SVH
// Assertion macros for the allocator; define NO_ASSERTIONS to drop them.
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is high
`define BFFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is high
`define BFFA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed: next-cycle implication");
`else
`define BFFA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BFFA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/bffa_pkg.sv
`timescale 1ns / 1ps
package bffa_pkg;

  // Heap geometry: one busy bit per heap word, eight words per map byte
  localparam int HEAP_WORDS = 1024;
  localparam int MAP_BYTES  = HEAP_WORDS / 8;
  localparam int MAP_AW     = $clog2(MAP_BYTES);
  localparam int WORD_AW    = $clog2(HEAP_WORDS);
  localparam int RUN_W      = WORD_AW + 1;
  localparam int SIZE_W     = 12;
  localparam int ADDR_W     = 10;
  localparam int SUM_W      = SIZE_W + 1;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_NOSPACE = 2'd1,
    RC_ERROR   = 2'd2
  } result_code_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic         load;       // capture an accepted request
    logic         scan_clr;   // restart the first-fit scan at byte 0
    logic         scan_rd;    // read the next map byte for the scan
    logic         take_addr;  // use the request address as run start
    logic         mark_init;  // set up byte range and masks of the run
    logic         mark_rd;    // read the next map byte of the run
    logic         finish;     // present the result
    result_code_t code;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic words_zero;
    logic too_big;
    logic free_oob;
    logic is_free;
    logic rd_done;
    logic hit;
    logic exhaust;
    logic mark_rd_more;
    logic mark_wdone;
  } sts_t;

endpackage

### hdl/bitmap_first_fit_allocator_unit.sv
// A rejected request is answered from the check state; a free marks the m map bytes of its run,
// and an allocate first scans the k map bytes before the fit, then marks the m bytes of the run.
// A failed allocate scans all 128 map bytes before it reports.
// The single-port bitmap read (one map byte per cycle) sets scan and mark time.
// One request at a time; the next may be accepted in the cycle the result shows.
// Synchronous reset clears state and marks every heap word free; the receiver cannot stall.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator_unit import bffa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [SIZE_W-1:0] size_bytes,
  input  logic [ADDR_W-1:0] word_address,
  output logic              done,
  output logic [ADDR_W-1:0] start_word,
  output logic [1:0]        result_code,
  output logic              overflow_seen
);

  cmd_t cmd;
  sts_t sts;

  bffa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bffa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .kind          (kind),
    .size_bytes    (size_bytes),
    .word_address  (word_address),
    .cmd           (cmd),
    .sts           (sts),
    .done          (done),
    .start_word    (start_word),
    .result_code   (result_code),
    .overflow_seen (overflow_seen)
  );

endmodule

### hdl/bffa_datapath.sv
`timescale 1ns / 1ps
`include "bitmap_first_fit_allocator_unit_assert.svh"
module bffa_datapath import bffa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              kind,
  input  logic [SIZE_W-1:0] size_bytes,
  input  logic [ADDR_W-1:0] word_address,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              done,
  output logic [ADDR_W-1:0] start_word,
  output logic [1:0]        result_code,
  output logic              overflow_seen
);

  // Request registers
  logic              kind_q;
  logic [SIZE_W-1:0] words_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SUM_W-1:0]  words_sum;

  // Bitmap memory with per-row valid bits
  logic [7:0]           mem [MAP_BYTES];
  logic [MAP_BYTES-1:0] row_vld;
  logic [7:0]           rd_data;
  logic                 rd_vbit;
  logic [7:0]           byte_q;
  logic                 rd_en;
  logic [MAP_AW-1:0]    rd_addr;

  // Scan state
  logic [MAP_AW:0]    scan_ptr;
  logic [MAP_AW-1:0]  scan_idx;
  logic               scan_vld;
  logic [RUN_W-1:0]   run;
  logic [RUN_W-1:0]   run_next;
  logic               found;
  logic [WORD_AW-1:0] found_pos;
  logic [WORD_AW-1:0] start_q;

  // Mark state
  logic [SUM_W-1:0]  last_word;
  logic [MAP_AW:0]   mark_ptr;
  logic [MAP_AW-1:0] mark_last;
  logic [2:0]        last_bit;
  logic [MAP_AW-1:0] wr_idx;
  logic              mark_wvld;
  logic [7:0]        lo_mask;
  logic [7:0]        hi_mask;
  logic [7:0]        mask;
  logic [7:0]        wr_data;

  logic ovf;

  // Round the byte size up to words
  assign words_sum = ({1'b0, size_bytes} + SUM_W'(1)) >> 1;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      words_q <= words_sum[SIZE_W-1:0];
      addr_q  <= word_address;
    end
  end

  // Request checks
  assign sts.words_zero = (words_q == '0);
  assign sts.too_big    = ({1'b0, words_q} > SUM_W'(HEAP_WORDS));
  assign sts.free_oob   = (SUM_W'(addr_q) + {1'b0, words_q} > SUM_W'(HEAP_WORDS));
  assign sts.is_free    = kind_q;

  // Select the single read port between scan and mark
  assign rd_en   = cmd.scan_rd | cmd.mark_rd;
  assign rd_addr = cmd.mark_rd ? mark_ptr[MAP_AW-1:0] : scan_ptr[MAP_AW-1:0];

  // Read and write the map
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (mark_wvld) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Hold valid bits and the registered row valid
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (mark_wvld) begin
      row_vld[wr_idx] <= 1'b1;
    end
    if (rd_en) begin
      rd_vbit <= row_vld[rd_addr];
    end
  end

  // A row never written reads as free
  assign byte_q = rd_vbit ? rd_data : '0;

  // Walk the eight words of the returned byte
  always_comb begin
    logic [RUN_W-1:0] r;
    logic             f;
    logic [SUM_W-1:0] pos;
    r         = run;
    f         = 1'b0;
    pos       = '0;
    found_pos = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte_q[b]) begin
        r = '0;
      end else begin
        r = r + RUN_W'(1);
      end
      if (!f && ({1'b0, r} == words_q)) begin
        f         = 1'b1;
        pos       = SUM_W'({scan_idx, 3'(b)}) + SUM_W'(1) - {1'b0, words_q};
        found_pos = pos[WORD_AW-1:0];
      end
    end
    run_next = r;
    found    = f;
  end

  assign sts.rd_done = (scan_ptr == (MAP_AW + 1)'(MAP_BYTES));
  assign sts.hit     = scan_vld & found;
  assign sts.exhaust = scan_vld & ~found & (scan_idx == MAP_AW'(MAP_BYTES - 1));

  // Advance the scan pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= cmd.scan_rd;
    end
    if (cmd.scan_clr) begin
      scan_ptr <= '0;
      run      <= '0;
    end else begin
      if (cmd.scan_rd) begin
        scan_ptr <= scan_ptr + (MAP_AW + 1)'(1);
        scan_idx <= scan_ptr[MAP_AW-1:0];
      end
      if (scan_vld) begin
        run <= run_next;
      end
    end
    if (sts.hit) begin
      start_q <= found_pos;
    end else if (cmd.take_addr) begin
      start_q <= WORD_AW'(addr_q);
    end
  end

  // Byte range of the run
  assign last_word = SUM_W'(start_q) + {1'b0, words_q} - SUM_W'(1);

  // Advance the read-modify-write pipeline over the run
  always_ff @(posedge clk) begin
    if (rst) begin
      mark_wvld <= 1'b0;
    end else begin
      mark_wvld <= cmd.mark_rd;
    end
    if (cmd.mark_init) begin
      mark_ptr  <= {1'b0, start_q[WORD_AW-1:3]};
      mark_last <= last_word[WORD_AW-1:3];
      last_bit  <= last_word[2:0];
    end else if (cmd.mark_rd) begin
      mark_ptr <= mark_ptr + (MAP_AW + 1)'(1);
      wr_idx   <= mark_ptr[MAP_AW-1:0];
    end
  end

  assign sts.mark_rd_more = (mark_ptr <= {1'b0, mark_last});
  assign sts.mark_wdone   = mark_wvld & (wr_idx == mark_last);

  // Trim the mask at the first and last byte of the run
  assign lo_mask = (wr_idx == start_q[WORD_AW-1:3]) ? (BYTE_ONES << start_q[2:0]) : BYTE_ONES;
  assign hi_mask = (wr_idx == mark_last) ? (BYTE_ONES >> (3'd7 - last_bit)) : BYTE_ONES;
  assign mask    = lo_mask & hi_mask;
  assign wr_data = kind_q ? (byte_q & ~mask) : (byte_q | mask);

  // Present the result and keep the sticky overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      ovf  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish && (cmd.code == RC_NOSPACE)) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.finish) begin
      result_code   <= cmd.code;
      start_word    <= ((cmd.code == RC_OK) && !kind_q) ? ADDR_W'(start_q) : '0;
      overflow_seen <= ovf | (cmd.code == RC_NOSPACE);
    end
  end

  `BFFA_ASSERT_IMP(a_wr_in_run, clk, rst, mark_wvld, wr_idx <= mark_last)
  `BFFA_ASSERT_IMP(a_fail_no_start, clk, rst, done && (result_code != RC_OK), start_word == '0)
  `BFFA_ASSERT_IMP(a_nospace_flag, clk, rst, done && (result_code == RC_NOSPACE), overflow_seen)

endmodule

### hdl/bffa_ctrl.sv
`timescale 1ns / 1ps
`include "bitmap_first_fit_allocator_unit_assert.svh"
module bffa_ctrl import bffa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MINIT,
    S_MARK
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.code   = RC_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.words_zero || (!sts.is_free && sts.too_big) ||
                     (sts.is_free && sts.free_oob)) begin
          cmd.finish = 1'b1;
          cmd.code   = RC_ERROR;
          state_next = S_IDLE;
        end else if (sts.is_free) begin
          cmd.take_addr = 1'b1;
          state_next    = S_MINIT;
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = !sts.rd_done && !sts.hit;
        // Hit and exhaustion never coincide; keep scanning otherwise
        if (sts.hit) begin
          state_next = S_MINIT;
        end else if (sts.exhaust) begin
          cmd.finish = 1'b1;
          cmd.code   = RC_NOSPACE;
          state_next = S_IDLE;
        end
      end
      S_MINIT: begin
        cmd.mark_init = 1'b1;
        state_next    = S_MARK;
      end
      S_MARK: begin
        cmd.mark_rd = sts.mark_rd_more;
        if (sts.mark_wdone) begin
          cmd.finish = 1'b1;
          cmd.code   = RC_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BFFA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `BFFA_ASSERT_NXT(a_hit_to_mark, clk, rst, (state == S_SCAN) && sts.hit, state == S_MINIT)
  `BFFA_ASSERT_NXT(a_finish_idle, clk, rst, cmd.finish, !busy)

endmodule

### bench/bitmap_first_fit_allocator_unit_test.sv
`timescale 1ns / 1ps
module bitmap_first_fit_allocator_unit_test;
  import bffa_pkg::*;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam int   RANDOM_REQUESTS = 1025;
  localparam int   BATCH_LEN = 8;
  localparam int   DRAIN_CYCLES = 300;

  typedef struct {
    logic              kind;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] word_address;
  } heap_request_t;

  typedef struct {
    logic [ADDR_W-1:0] start_word;
    result_code_t      code;
    logic              overflow;
  } heap_outcome_t;

  typedef struct {
    int first;
    int bytes;
  } live_run_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              kind = KIND_ALLOC;
  logic [SIZE_W-1:0] size_bytes = '0;
  logic [ADDR_W-1:0] word_address = '0;
  logic              done;
  logic [ADDR_W-1:0] start_word;
  logic [1:0]        result_code;
  logic              overflow_seen;

  heap_request_t     request_queue[$];
  heap_outcome_t     expected_outcomes[$];
  live_run_t         live_runs[$];

  // Shadow of the allocator state
  logic [HEAP_WORDS-1:0] heap_busy;
  logic                  overflow_state;

  logic req_taken = 1'b0;
  logic wait_result = 1'b0;
  logic no_idle_stretch = 1'b0;
  int   gap_left = 0;
  int   taken_total = 0;
  int   results_seen = 0;
  int   fail_count = 0;
  int   placed_count = 0;
  int   nospace_count = 0;
  int   invalid_count = 0;
  int   free_count = 0;

  bitmap_first_fit_allocator_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .size_bytes   (size_bytes),
    .word_address (word_address),
    .done         (done),
    .start_word   (start_word),
    .result_code  (result_code),
    .overflow_seen(overflow_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to the shadow heap and return the outcome it should give
  function automatic heap_outcome_t apply_heap_request(input heap_request_t req);
    heap_outcome_t res;
    int n_words;
    int run_len;
    int found;
    int w;
    res.start_word = '0;
    res.code = RC_OK;
    n_words = (int'(req.size_bytes) + 1) >> 1;
    run_len = 0;
    found = -1;
    if (n_words == 0) begin
      res.code = RC_ERROR;
    end else if (req.kind == KIND_ALLOC) begin
      if (n_words > HEAP_WORDS) begin
        res.code = RC_ERROR;
      end else begin
        // first fit: lowest run of free words long enough
        for (w = 0; w < HEAP_WORDS && found < 0; w++) begin
          if (heap_busy[w]) begin
            run_len = 0;
          end else begin
            run_len++;
            if (run_len == n_words) found = w + 1 - n_words;
          end
        end
        if (found >= 0) begin
          for (w = found; w < found + n_words; w++) heap_busy[w] = 1'b1;
          res.start_word = ADDR_W'(found);
        end else begin
          res.code = RC_NOSPACE;
          overflow_state = 1'b1;
        end
      end
    end else if (int'(req.word_address) + n_words > HEAP_WORDS) begin
      res.code = RC_ERROR;
    end else begin
      for (w = int'(req.word_address); w < int'(req.word_address) + n_words; w++)
        heap_busy[w] = 1'b0;
    end
    res.overflow = overflow_state;
    return res;
  endfunction

  task automatic queue_request(input logic k, input int sz, input int addr);
    heap_request_t req;
    req.kind = k;
    req.size_bytes = SIZE_W'(sz);
    req.word_address = ADDR_W'(addr);
    request_queue.push_back(req);
  endtask

  // Mostly well-formed traffic: allocations and frees of live runs, plus noise
  task automatic queue_random_batch(input int count);
    int i;
    int pick;
    int sz;
    int idx;
    live_run_t run;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        sz = $urandom_range(0, 99);
        if (sz < 70) sz = $urandom_range(1, 48);
        else if (sz < 90) sz = $urandom_range(49, 400);
        else if (sz < 96) sz = $urandom_range(401, 2048);
        else sz = $urandom_range(0, 4095);
        queue_request(KIND_ALLOC, sz, $urandom_range(0, 1023));
      end else if (pick < 80 && live_runs.size() > 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        queue_request(KIND_FREE, run.bytes, run.first);
      end else if (pick < 82) begin
        live_runs.delete();
        queue_request(KIND_FREE, 2048, 0);
      end else begin
        sz = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(0, 4095);
        queue_request(KIND_FREE, sz, $urandom_range(0, 1023));
      end
    end
  endtask

  // Drive requests at the falling edge; hold each until taken, then maybe idle
  always @(negedge clk) begin : drive_requests
    heap_request_t req;
    int   this_gap;
    logic wait_res;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
      wait_result <= 1'b0;
    end else if (start && !req_taken) begin
      // hold the request until the block takes it
    end else begin
      if (start) begin
        this_gap = no_idle_stretch ? 0 : $urandom_range(0, 5);
        wait_res = ($urandom_range(0, 3) == 0);
      end else begin
        this_gap = gap_left;
        wait_res = wait_result;
      end
      if (wait_res && results_seen != taken_total) begin
        start <= 1'b0;
        gap_left <= this_gap;
        wait_result <= 1'b1;
      end else if (this_gap > 0) begin
        start <= 1'b0;
        gap_left <= this_gap - 1;
        wait_result <= 1'b0;
      end else if (request_queue.size() > 0) begin
        req = request_queue.pop_front();
        kind <= req.kind;
        size_bytes <= req.size_bytes;
        word_address <= req.word_address;
        start <= 1'b1;
        gap_left <= 0;
        wait_result <= 1'b0;
      end else begin
        start <= 1'b0;
        wait_result <= 1'b0;
      end
    end
  end

  // Check results and predict each request as it is taken
  always @(posedge clk) begin : check_results
    heap_request_t req;
    heap_outcome_t want;
    if (rst) begin
      heap_busy = '0;
      overflow_state = 1'b0;
      req_taken <= 1'b0;
    end else begin
      if (done) begin
        results_seen <= results_seen + 1;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result: start_word %0d code %0d overflow %0b", $time,
                   start_word, result_code, overflow_seen);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (start_word !== want.start_word) begin
            $display("%0t: start_word expected %0d actual %0d", $time, want.start_word,
                     start_word);
            fail_count++;
          end
          if (result_code !== want.code) begin
            $display("%0t: result_code expected %0d actual %0d", $time, want.code,
                     result_code);
            fail_count++;
          end
          if (overflow_seen !== want.overflow) begin
            $display("%0t: overflow_seen expected %0b actual %0b", $time, want.overflow,
                     overflow_seen);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        req.kind = kind;
        req.size_bytes = size_bytes;
        req.word_address = word_address;
        want = apply_heap_request(req);
        expected_outcomes.push_back(want);
        taken_total <= taken_total + 1;
        if (want.code == RC_ERROR) invalid_count++;
        else if (want.code == RC_NOSPACE) nospace_count++;
        else if (req.kind == KIND_FREE) free_count++;
        else begin
          placed_count++;
          live_runs.push_back('{int'(want.start_word), int'(req.size_bytes)});
        end
      end
      req_taken <= start && !busy;
    end
  end

  // Stimulus and end of run
  initial begin : run_stimulus
    int random_sent;
    random_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero sizes, small fits, map byte crossing, oversize and no-space cases
    queue_request(KIND_ALLOC, 0, 0);
    queue_request(KIND_FREE, 0, 5);
    queue_request(KIND_ALLOC, 1, 1023);
    queue_request(KIND_ALLOC, 2, 0);
    queue_request(KIND_ALLOC, 3, 0);
    queue_request(KIND_ALLOC, 15, 0);
    queue_request(KIND_ALLOC, 2050, 0);
    queue_request(KIND_ALLOC, 4095, 1023);
    queue_request(KIND_ALLOC, 2048, 0);
    queue_request(KIND_FREE, 2, 1);
    queue_request(KIND_ALLOC, 4, 0);
    queue_request(KIND_ALLOC, 1, 0);
    // frees at the heap end, past it, and of words already free
    queue_request(KIND_FREE, 2, 1023);
    queue_request(KIND_FREE, 3, 1023);
    queue_request(KIND_FREE, 4095, 1023);
    queue_request(KIND_FREE, 200, 600);
    // whole-heap runs
    queue_request(KIND_FREE, 2048, 0);
    queue_request(KIND_ALLOC, 2048, 0);
    queue_request(KIND_ALLOC, 1, 0);
    queue_request(KIND_FREE, 2047, 0);
    queue_request(KIND_ALLOC, 2047, 0);
    queue_request(KIND_FREE, 1024, 512);
    queue_request(KIND_ALLOC, 1025, 0);
    queue_request(KIND_ALLOC, 1024, 0);
    queue_request(KIND_FREE, 2048, 0);
    while (request_queue.size() != 0 || start) @(negedge clk);
    while (expected_outcomes.size() != 0) @(negedge clk);
    live_runs.delete();

    // random traffic in batches, some of them with no random idle gap
    while (random_sent < RANDOM_REQUESTS) begin
      no_idle_stretch = ($urandom_range(0, 4) == 0);
      queue_random_batch(BATCH_LEN);
      random_sent += BATCH_LEN;
      while (request_queue.size() != 0) @(negedge clk);
    end

    // drain: wait out every expected result, then watch for strays
    while (start) @(negedge clk);
    while (expected_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d requests: %0d runs placed, %0d frees, %0d refused for lack of space,",
             taken_total, placed_count, free_count, nospace_count);
    $display("%0d rejected for zero size or range; %0d mismatches.", invalid_count, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d results outstanding", expected_outcomes.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### bitmap_first_fit_allocator_unit.f
+incdir+hdl
hdl/bffa_pkg.sv
hdl/bffa_datapath.sv
hdl/bffa_ctrl.sv
hdl/bitmap_first_fit_allocator_unit.sv
bench/bitmap_first_fit_allocator_unit_test.sv
